FILE: hw/rtl/gmt_pkg.sv
// ----------------------------------------------------------------------------
// gmt_pkg: shared types and constants of the membership table
// opcodes, status codes, widths and the controller-to-datapath command struct
// ----------------------------------------------------------------------------
`default_nettype none
package gmt_pkg;
   localparam int MaxMembers = 32;
   localparam int SlotW      = $clog2(MaxMembers);
   localparam int CountW     = 6;
   localparam int GossipB    = 2;

   localparam logic [2:0] OP_MERGE = 3'd0;
   localparam logic [2:0] OP_TICK  = 3'd1;
   localparam logic [2:0] OP_SWEEP = 3'd2;
   localparam logic [2:0] OP_READ  = 3'd3;
   localparam logic [2:0] OP_JOIN  = 3'd4;

   localparam logic [3:0] ST_ADDED     = 4'd0;
   localparam logic [3:0] ST_UPDATED   = 4'd1;
   localparam logic [3:0] ST_UNCHANGED = 4'd2;
   localparam logic [3:0] ST_FULL      = 4'd3;
   localparam logic [3:0] ST_REMOVED   = 4'd4;
   localparam logic [3:0] ST_DONE      = 4'd5;
   localparam logic [3:0] ST_BUMPED    = 4'd6;
   localparam logic [3:0] ST_ALONE     = 4'd7;
   localparam logic [3:0] ST_READ      = 4'd8;
   localparam logic [3:0] ST_EMPTY     = 4'd9;
   localparam logic [3:0] ST_JOINED    = 4'd10;

   localparam logic [1:0] CSR_SELF_ID   = 2'd0;
   localparam logic [1:0] CSR_SELF_PORT = 2'd1;
   localparam logic [1:0] CSR_TIMEOUT   = 2'd2;

   // request fields held for the whole operation
   typedef struct packed {
      logic [2:0]  opcode;
      logic [31:0] entry_id;
      logic [15:0] entry_port;
      logic [31:0] entry_heartbeat;
      logic [31:0] now_time;
      logic [4:0]  read_slot;
      logic        message_end;
   } req_type;

   // controller commands for one cycle
   typedef struct packed {
      logic             load;     // capture request
      logic             rd;       // read slot addr into read register
      logic [SlotW-1:0] addr;
      logic             do_join;
      logic             update;   // merge update at hit slot
      logic             insert;   // insert at free slot
      logic             bump;     // tick self slot
      logic             remove;   // remove slot in read register
      logic             emit;     // load output register
      logic [3:0]       status;
      logic             use_rd;   // output fields from read register
      logic             use_req;  // output fields from request (full)
      logic             last;
   } cmd_type;

   // datapath status back to controller
   typedef struct packed {
      logic             rd_valid;    // valid bit of registered slot
      logic             match;       // registered slot matches request
      logic             newer;       // incoming heartbeat greater
      logic             expired;     // registered slot aged out
      logic             free_found;
      logic [SlotW-1:0] free_slot;
      logic             self_valid;
      logic [CountW-1:0] count;
      logic             out_busy;    // output register still occupied
   } stat_type;
endpackage
`default_nettype wire

FILE: hw/rtl/gmt_datapath.sv
// ----------------------------------------------------------------------------
// gmt_datapath: slot memory, valid bits, output register
// executes one controller command per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module gmt_datapath import gmt_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [31:0]       self_id,
   input  wire logic [15:0]       self_port,
   input  wire logic [15:0]       remove_timeout,
   input  wire req_type           req_in,
   input  wire cmd_type           cmd,
   output stat_type               stat,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output logic [3:0]             out_status,
   output logic [31:0]            out_id,
   output logic [15:0]            out_port,
   output logic [31:0]            out_heartbeat,
   output logic [31:0]            out_stamp,
   output logic [CountW-1:0]      out_count,
   output logic                   out_mdone,
   output logic                   out_last
);
   logic [31:0] mem_id    [MaxMembers];
   logic [15:0] mem_port  [MaxMembers];
   logic [31:0] mem_beat  [MaxMembers];
   logic [31:0] mem_stamp [MaxMembers];

   logic [MaxMembers-1:0] valid_ff, valid_in;
   logic [CountW-1:0]     count_ff, count_in;
   req_type               req_ff;
   logic [SlotW-1:0]      raddr_ff;
   logic [31:0]           rid_ff, rbeat_ff, rstamp_ff;
   logic [15:0]           rport_ff;
   logic                  ovalid_ff;
   logic [3:0]            ostatus_ff;
   logic [31:0]           oid_ff, obeat_ff, ostamp_ff;
   logic [15:0]           oport_ff;
   logic [CountW-1:0]     ocount_ff;
   logic                  omdone_ff, olast_ff;

   logic                  wr_en;
   logic [SlotW-1:0]      wr_addr;
   logic [31:0]           wr_id, wr_beat, wr_stamp;
   logic [15:0]           wr_port;
   logic [31:0]           age;
   logic                  free_found;
   logic [SlotW-1:0]      free_slot;

   // write port selection
   always_comb begin
      wr_en    = 1'b0;
      wr_addr  = raddr_ff;
      wr_id    = rid_ff;
      wr_port  = rport_ff;
      wr_beat  = req_ff.entry_heartbeat;
      wr_stamp = req_ff.now_time;
      if (cmd.do_join) begin
         wr_en   = 1'b1;
         wr_addr = '0;
         wr_id   = self_id;
         wr_port = self_port;
         wr_beat = '0;
      end else if (cmd.update) begin
         wr_en = 1'b1;
      end else if (cmd.insert) begin
         wr_en   = 1'b1;
         wr_addr = free_slot;
         wr_id   = req_ff.entry_id;
         wr_port = req_ff.entry_port;
      end else if (cmd.bump) begin
         wr_en   = 1'b1;
         wr_addr = '0;
         wr_beat = (rbeat_ff == 32'hFFFF_FFFF) ? rbeat_ff : rbeat_ff + 32'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_id[wr_addr]    <= wr_id;
         mem_port[wr_addr]  <= wr_port;
         mem_beat[wr_addr]  <= wr_beat;
         mem_stamp[wr_addr] <= wr_stamp;
      end
      if (cmd.rd) begin
         rid_ff    <= mem_id[cmd.addr];
         rport_ff  <= mem_port[cmd.addr];
         rbeat_ff  <= mem_beat[cmd.addr];
         rstamp_ff <= mem_stamp[cmd.addr];
         raddr_ff  <= cmd.addr;
      end
      if (cmd.load) req_ff <= req_in;
   end

   // lowest free slot from one up
   always_comb begin
      free_found = 1'b0;
      free_slot  = '0;
      for (int i = MaxMembers - 1; i >= 1; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_slot  = SlotW'(i);
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      count_in = count_ff;
      if (cmd.do_join) begin
         valid_in    = '0;
         valid_in[0] = 1'b1;
         count_in    = CountW'(1);
      end else if (cmd.insert) begin
         valid_in[free_slot] = 1'b1;
         count_in = count_ff + CountW'(1);
      end else if (cmd.remove) begin
         valid_in[raddr_ff] = 1'b0;
         count_in = count_ff - CountW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
      end
   end

   assign age = (req_ff.now_time >= rstamp_ff) ? req_ff.now_time - rstamp_ff : 32'd0;

   always_comb begin
      stat.rd_valid   = valid_ff[raddr_ff];
      stat.match      = (rid_ff == req_ff.entry_id) && (rport_ff == req_ff.entry_port);
      stat.newer      = req_ff.entry_heartbeat > rbeat_ff;
      stat.expired    = age >= {16'd0, remove_timeout};
      stat.free_found = free_found;
      stat.free_slot  = free_slot;
      stat.self_valid = valid_ff[0];
      stat.count      = count_ff;
      stat.out_busy   = ovalid_ff && !out_ready;
   end

   // output register; count shows state after this result
   always_ff @(posedge clock) begin
      if (reset) begin
         ovalid_ff <= 1'b0;
      end else if (cmd.emit) begin
         ovalid_ff <= 1'b1;
      end else if (out_ready) begin
         ovalid_ff <= 1'b0;
      end
      if (cmd.emit) begin
         ostatus_ff <= cmd.status;
         ocount_ff  <= count_in;
         olast_ff   <= cmd.last;
         omdone_ff  <= (req_ff.opcode == OP_MERGE) ? req_ff.message_end : 1'b0;
         if (cmd.do_join || cmd.update || cmd.insert || cmd.bump) begin
            oid_ff    <= wr_id;
            oport_ff  <= wr_port;
            obeat_ff  <= wr_beat;
            ostamp_ff <= wr_stamp;
         end else if (cmd.use_rd) begin
            oid_ff    <= rid_ff;
            oport_ff  <= rport_ff;
            obeat_ff  <= rbeat_ff;
            ostamp_ff <= rstamp_ff;
         end else if (cmd.use_req) begin
            oid_ff    <= req_ff.entry_id;
            oport_ff  <= req_ff.entry_port;
            obeat_ff  <= req_ff.entry_heartbeat;
            ostamp_ff <= '0;
         end else begin
            oid_ff    <= '0;
            oport_ff  <= '0;
            obeat_ff  <= '0;
            ostamp_ff <= '0;
         end
      end
   end

   assign out_valid     = ovalid_ff;
   assign out_status    = ostatus_ff;
   assign out_id        = oid_ff;
   assign out_port      = oport_ff;
   assign out_heartbeat = obeat_ff;
   assign out_stamp     = ostamp_ff;
   assign out_count     = ocount_ff;
   assign out_mdone     = omdone_ff;
   assign out_last      = olast_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountW'(MaxMembers))
      else $error("member count out of range");
   a_count_match: assert property (@(posedge clock) disable iff (reset)
      count_ff == CountW'($countones(valid_ff)) || !valid_ff[0] && count_ff == '0)
      else $error("member count differs from valid bits");
   a_one_write: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.do_join, cmd.update, cmd.insert, cmd.bump, cmd.remove}))
      else $error("two table writes in one cycle");
endmodule
`default_nettype wire

FILE: hw/rtl/gmt_controller.sv
// ----------------------------------------------------------------------------
// gmt_controller: sequencer of the membership table operations
// while the output register is free, scans slots one per cycle for merge and sweep
// ----------------------------------------------------------------------------
`default_nettype none
module gmt_controller import gmt_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   input  wire logic [2:0] req_opcode,
   input  wire logic [4:0] req_read_slot,
   input  wire stat_type stat,
   output cmd_type       cmd
);
   typedef enum logic [2:0] {
      S_IDLE, S_MSCAN, S_SSCAN, S_TICK, S_READ, S_DONE
   } state_type;

   state_type        state_ff;
   logic [SlotW:0]   idx_ff;     // slot of data now in read register
   logic             last_ff;    // read register holds final scan slot
   logic [4:0]       rslot_ff;

   always_comb begin
      req_ready = (state_ff == S_IDLE) && !stat.out_busy;
      cmd = '0;
      cmd.addr = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.load = 1'b1;
               cmd.rd   = 1'b1;
               if (req_opcode == OP_SWEEP) begin
                  cmd.addr = SlotW'(1);
               end else if (req_opcode == OP_READ) begin
                  cmd.addr = SlotW'(req_read_slot);
               end else begin
                  cmd.addr = '0;
               end
            end
         end
         S_MSCAN: begin
            if (!stat.out_busy) begin
               if (stat.rd_valid && stat.match) begin
                  cmd.emit = 1'b1; cmd.last = 1'b1;
                  if (stat.newer) begin
                     cmd.update = 1'b1; cmd.status = ST_UPDATED;
                  end else begin
                     cmd.use_rd = 1'b1; cmd.status = ST_UNCHANGED;
                  end
               end else if (last_ff) begin
                  cmd.emit = 1'b1; cmd.last = 1'b1;
                  if (stat.free_found) begin
                     cmd.insert = 1'b1; cmd.status = ST_ADDED;
                  end else begin
                     cmd.use_req = 1'b1; cmd.status = ST_FULL;
                  end
               end else begin
                  cmd.rd   = 1'b1;
                  cmd.addr = idx_ff[SlotW-1:0] + SlotW'(1);
               end
            end
         end
         S_SSCAN: begin
            if (!stat.out_busy) begin
               if (stat.rd_valid && stat.expired) begin
                  cmd.remove = 1'b1; cmd.emit = 1'b1;
                  cmd.use_rd = 1'b1; cmd.status = ST_REMOVED;
               end
               if (!last_ff) begin
                  cmd.rd   = 1'b1;
                  cmd.addr = idx_ff[SlotW-1:0] + SlotW'(1);
               end
            end
         end
         S_DONE: begin
            if (!stat.out_busy) begin
               cmd.emit = 1'b1; cmd.last = 1'b1; cmd.status = ST_DONE;
            end
         end
         S_TICK: begin
            if (!stat.out_busy) begin
               cmd.emit = 1'b1; cmd.last = 1'b1;
               if (stat.self_valid && stat.count >= CountW'(2)) begin
                  cmd.bump = 1'b1; cmd.status = ST_BUMPED;
               end else begin
                  cmd.use_rd = stat.self_valid; cmd.status = ST_ALONE;
               end
            end
         end
         S_READ: begin
            if (!stat.out_busy) begin
               cmd.emit = 1'b1; cmd.last = 1'b1;
               if (stat.rd_valid && 32'(rslot_ff) < 32'(MaxMembers)) begin
                  cmd.use_rd = 1'b1; cmd.status = ST_READ;
               end else begin
                  cmd.status = ST_EMPTY;
               end
            end
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
         last_ff  <= 1'b0;
         rslot_ff <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid && req_ready) begin
                  rslot_ff <= req_read_slot;
                  idx_ff   <= (req_opcode == OP_SWEEP) ? (SlotW+1)'(1) : '0;
                  last_ff  <= 1'b0;
                  case (req_opcode)
                     OP_MERGE: state_ff <= S_MSCAN;
                     OP_SWEEP: state_ff <= S_SSCAN;
                     OP_TICK:  state_ff <= S_TICK;
                     OP_READ:  state_ff <= S_READ;
                     OP_JOIN:  state_ff <= S_TICK;
                     default:  state_ff <= S_IDLE;
                  endcase
               end
            end
            S_MSCAN, S_SSCAN: begin
               if (cmd.emit && cmd.last) begin
                  state_ff <= S_IDLE;
               end else if (!stat.out_busy) begin
                  if (last_ff) begin
                     state_ff <= S_DONE;
                  end else begin
                     idx_ff  <= idx_ff + (SlotW+1)'(1);
                     last_ff <= (idx_ff + (SlotW+1)'(1)) == (SlotW+1)'(MaxMembers - 1);
                  end
               end
            end
            S_TICK, S_READ, S_DONE: begin
               if (cmd.emit) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff < (SlotW+1)'(MaxMembers))
      else $error("scan index out of range");
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req_ready)
      else $error("request taken while busy");
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !stat.out_busy)
      else $error("result overwritten");
endmodule
`default_nettype wire

FILE: hw/rtl/gmt_join_mux.sv
// ----------------------------------------------------------------------------
// gmt_join_mux: splits the tick state into tick and join commands
// join writes self into slot zero and clears the other slots
// ----------------------------------------------------------------------------
`default_nettype none
module gmt_join_mux import gmt_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_take,
   input  wire logic [2:0] req_opcode,
   input  wire cmd_type cmd_raw,
   output cmd_type      cmd
);
   logic join_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         join_ff <= 1'b0;
      end else if (req_take) begin
         join_ff <= (req_opcode == OP_JOIN);
      end else if (cmd_raw.emit) begin
         join_ff <= 1'b0;
      end
   end

   // a pending join turns the tick emit into a join write
   always_comb begin
      cmd = cmd_raw;
      if (join_ff && cmd_raw.emit) begin
         cmd.bump    = 1'b0;
         cmd.use_rd  = 1'b0;
         cmd.do_join = 1'b1;
         cmd.status  = ST_JOINED;
      end
   end
endmodule
`default_nettype wire

FILE: hw/rtl/gossip_membership_table_top.sv
// ----------------------------------------------------------------------------
// gossip_membership_table_top: heartbeat membership table of a gossip node
// join, merge, tick, expire sweep and read over a 32-slot table
// ----------------------------------------------------------------------------
// tick, read and join register the request, then register the result in the output register
// merge scans one slot a cycle, from slot 0 up to slot MaxMembers-1
// sweep scans slots 1 up one a cycle, one removal result per cycle, done item last
// one request at a time: the next is taken once the last result is registered
// and the output register is free; a stalled result stalls the scan
// reset clears valid bits, member count, state, output valid and config (timeout 25)
`default_nettype none
module gossip_membership_table_top import gmt_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // opcode[2:0], entry_id[34:3], entry_port[50:35], entry_heartbeat[82:51],
   // now_time[114:83], read_slot[119:115], zero fill [127:120]
   input  wire logic [127:0] req_tdata,
   input  wire logic        req_tlast,      // message_end
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // status[3:0], out_id[35:4], out_port[51:36], out_heartbeat[83:52],
   // out_stamp[115:84], member_count[121:116], message_done[122], zero [127:123]
   output logic [127:0]     rsp_tdata,
   output logic             rsp_tlast,      // last
   // configuration write channel
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_data
);
   logic [31:0] self_id_ff;
   logic [15:0] self_port_ff, timeout_ff;
   req_type     req_in;
   cmd_type     cmd_raw, cmd;
   stat_type    stat;
   logic [3:0]  o_status;
   logic [31:0] o_id, o_beat, o_stamp;
   logic [15:0] o_port;
   logic [CountW-1:0] o_count;
   logic        o_mdone;

   // configuration registers, always writable
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         self_id_ff   <= '0;
         self_port_ff <= '0;
         timeout_ff   <= 16'd25;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SELF_ID:   self_id_ff   <= csr_data;
            CSR_SELF_PORT: self_port_ff <= csr_data[15:0];
            CSR_TIMEOUT:   timeout_ff   <= csr_data[15:0];
            default:       ;
         endcase
      end
   end

   // unpack request fields
   assign req_in.opcode          = req_tdata[2:0];
   assign req_in.entry_id        = req_tdata[34:3];
   assign req_in.entry_port      = req_tdata[50:35];
   assign req_in.entry_heartbeat = req_tdata[82:51];
   assign req_in.now_time        = req_tdata[114:83];
   assign req_in.read_slot       = req_tdata[119:115];
   assign req_in.message_end     = req_tlast;

   gmt_controller u_ctrl (
      .clock, .reset,
      .req_valid     (req_tvalid),
      .req_ready     (req_tready),
      .req_opcode    (req_tdata[2:0]),
      .req_read_slot (req_tdata[119:115]),
      .stat,
      .cmd           (cmd_raw)
   );

   gmt_join_mux u_join (
      .clock, .reset,
      .req_take   (req_tvalid && req_tready),
      .req_opcode (req_tdata[2:0]),
      .cmd_raw,
      .cmd
   );

   gmt_datapath u_dp (
      .clock, .reset,
      .self_id        (self_id_ff),
      .self_port      (self_port_ff),
      .remove_timeout (timeout_ff),
      .req_in,
      .cmd,
      .stat,
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .out_status     (o_status),
      .out_id         (o_id),
      .out_port       (o_port),
      .out_heartbeat  (o_beat),
      .out_stamp      (o_stamp),
      .out_count      (o_count),
      .out_mdone      (o_mdone),
      .out_last       (rsp_tlast)
   );

   assign rsp_tdata = {5'd0, o_mdone, o_count, o_stamp, o_beat, o_port, o_id, o_status};
endmodule
`default_nettype wire
